// ===== rtl/lzw_pkg.sv =====
// Package for the LZ77 window match finder: sizes, payload structs, codes.
// No dependencies; imported by lzw_cell and lz77_window_match_finder.
`default_nettype none
package lzw_pkg;

  localparam int WIN_DEPTH = 1024;
  localparam int LA_DEPTH  = 16;
  localparam int WIN_AW    = $clog2(WIN_DEPTH);
  localparam int FILL_W    = WIN_AW + 1;
  localparam int LA_AW     = $clog2(LA_DEPTH);
  localparam int LEN_W     = LA_AW + 1;
  localparam int GRP       = 32;
  localparam int GRP_AW    = $clog2(GRP);
  localparam int NGRP      = WIN_DEPTH / GRP;
  localparam int NGRP_AW   = $clog2(NGRP);
  localparam int CFG_W     = 11;

  localparam logic [1:0] MODE_LOAD    = 2'd0;
  localparam logic [1:0] MODE_SEARCH  = 2'd1;
  localparam logic [1:0] MODE_LITERAL = 2'd2;

  localparam logic CFG_WINDOW    = 1'b0;
  localparam logic CFG_LOOKAHEAD = 1'b1;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] position;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  match_length;
    logic [10:0] match_offset;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_ADV,
    OP_INSERT,
    OP_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t   op;
    logic [7:0] la_byte;
    logic [7:0] push_byte;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/lzw_cell.sv =====
// One window cell: a window byte, a shifting compare copy and a run flag.
// Depends on lzw_pkg.
`default_nettype none
module lzw_cell import lzw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  logic [7:0] win_nb,
  input  logic [7:0] win_pb,
  input  logic [7:0] s_nb,
  input  logic       v_nb,
  input  logic       sel,
  input  logic       above,
  input  logic       in_range,
  output logic [7:0] win_q,
  output logic [7:0] s_q,
  output logic       v_q,
  output logic       hit,
  output logic       alive_q
);

  logic [7:0] win_r, win_nxt, s_r, s_nxt;
  logic       v_r, v_nxt, alive_r, alive_nxt;

  // still matching and the shifted byte equals this step's lookahead byte
  assign hit = alive_r & v_r & (s_r == ctrl.la_byte);

  always_comb begin
    win_nxt   = win_r;
    s_nxt     = s_r;
    v_nxt     = v_r;
    alive_nxt = alive_r;
    case (ctrl.op)
      OP_LOAD: begin
        s_nxt     = win_r;
        v_nxt     = in_range;
        alive_nxt = in_range;
      end
      OP_ADV: begin
        s_nxt     = s_nb;
        v_nxt     = v_nb;
        alive_nxt = hit;
      end
      // write the selected slot, cells past it move up by one
      OP_INSERT: begin
        if (sel)        win_nxt = ctrl.push_byte;
        else if (above) win_nxt = win_pb;
      end
      OP_SHIFT:  win_nxt = sel ? ctrl.push_byte : win_nb;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    s_r   <= s_nxt;
    v_r   <= v_nxt;
    if (!rst_n) alive_r <= 1'b0;
    else        alive_r <= alive_nxt;
  end

  assign win_q   = win_r;
  assign s_q     = s_r;
  assign v_q     = v_r;
  assign alive_q = alive_r;

endmodule
`default_nettype wire

// ===== rtl/lz77_window_match_finder.sv =====
// LZ77 sliding-window longest-match finder: top level, control and encoder.
// Depends on lzw_pkg and lzw_cell.
//
// Usage: in_valid/in_ready carry one command transfer (mode, position,
// byte_value). Mode 0 writes a lookahead byte, mode 2 moves one lookahead
// byte into the window, mode 1 searches and returns one out_* transfer
// (match_length, match_offset), then moves the matched bytes into the window.
// Mode 3 is ignored. cfg_we writes window_size (index 0) or
// lookahead_size (index 1) in the same cycle; the user must write them only
// while the block is idle, the block itself does not enforce it.
// The window lives in a row of 1024 cells kept in oldest-to-newest order.
// A search loads a compare copy into every cell, then shifts it one cell per
// cycle while the lookahead byte for that step is broadcast; a match is at
// most lookahead_size bytes long. Registered priority encoding (32 cells a
// group: group registers, then the index register) picks the newest longest
// run, the result register is loaded, and then the matched bytes are pushed
// into the window in order.
// in_ready is high only when idle. A result waits in the output register
// while out_ready is low; the block stalls only when a second result is due.
// Reset (rst_n low, synchronous) empties the window, zeroes the lookahead
// head and sets both sizes to their maximum; window bytes need no clearing.
`default_nettype none
module lz77_window_match_finder import lzw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CMP  = 6'b000010,
    S_ENC1 = 6'b000100,
    S_ENC2 = 6'b001000,
    S_RES  = 6'b010000,
    S_CONS = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [10:0]       wsize_r, wsize_nxt;
  logic [4:0]        lsize_r, lsize_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt, effw;
  logic [WIN_AW-1:0] head_r, head_nxt;
  logic [LEN_W-1:0]  effl;
  logic [LA_AW-1:0]  lh_r, lh_nxt, li_r, li_nxt, lh_norm;
  logic [LEN_W-1:0]  t_r, t_nxt, len_r, len_nxt, cnt_r, cnt_nxt;
  logic [7:0]        la_r [LA_DEPTH];
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic [WIN_AW-1:0] j_r, j_nxt, push_tgt;
  logic              grp_any_r [NGRP];
  logic [GRP_AW-1:0] grp_idx_r [NGRP];
  logic              grp_any_c [NGRP];
  logic [GRP_AW-1:0] grp_idx_c [NGRP];

  logic [WIN_DEPTH-1:0] hit_v, alive_v, v_v;
  logic [7:0]           win_a [WIN_DEPTH];
  logic [7:0]           s_a   [WIN_DEPTH];
  cell_ctrl_t           ctrl;
  logic                 any_hit, full, in_xfer;

  // effective sizes, out-of-range values clamp
  always_comb begin
    if (wsize_r == '0)                      effw = FILL_W'(1);
    else if (wsize_r > 11'(WIN_DEPTH))      effw = FILL_W'(WIN_DEPTH);
    else                                    effw = FILL_W'(wsize_r);
    if (lsize_r == '0)                      effl = LEN_W'(1);
    else if (lsize_r > 5'(LA_DEPTH))        effl = LEN_W'(LA_DEPTH);
    else                                    effl = LEN_W'(lsize_r);
  end

  assign lh_norm  = (LEN_W'(lh_r) >= effl) ? '0 : lh_r;
  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid & in_ready;
  assign any_hit  = |hit_v;
  assign full     = (fill_r >= effw);
  // head_r is the ring's write head: once the ring has wrapped and the window
  // is enlarged again, a new byte goes in just ahead of the head's slot.
  // When full, shift left and write the newest slot.
  assign push_tgt = full ? WIN_AW'(fill_r - FILL_W'(1))
                         : WIN_AW'(fill_r - FILL_W'(head_r));

  // cell row
  for (genvar j = 0; j < WIN_DEPTH; j++) begin : g_cell
    logic [7:0] win_nb, win_pb, s_nb;
    logic       v_nb;
    if (j == WIN_DEPTH - 1) begin : g_end
      assign win_nb = '0;
      assign s_nb   = '0;
      assign v_nb   = 1'b0;
    end else begin : g_mid
      assign win_nb = win_a[j+1];
      assign s_nb   = s_a[j+1];
      assign v_nb   = v_v[j+1];
    end
    if (j == 0) begin : g_first
      assign win_pb = '0;
    end else begin : g_rest
      assign win_pb = win_a[j-1];
    end
    lzw_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .win_nb   (win_nb),
      .win_pb   (win_pb),
      .s_nb     (s_nb),
      .v_nb     (v_nb),
      .sel      (push_tgt == WIN_AW'(j)),
      .above    (WIN_AW'(j) > push_tgt),
      .in_range (FILL_W'(j) < fill_r),
      .win_q    (win_a[j]),
      .s_q      (s_a[j]),
      .v_q      (v_v[j]),
      .hit      (hit_v[j]),
      .alive_q  (alive_v[j])
    );
  end

  // first encoder level: newest live cell within each group
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_any_c[g] = 1'b0;
      grp_idx_c[g] = '0;
      for (int b = 0; b < GRP; b++) begin
        if (alive_v[g*GRP + b]) begin
          grp_any_c[g] = 1'b1;
          grp_idx_c[g] = GRP_AW'(b);
        end
      end
    end
  end

  // second encoder level: newest group that has a live cell
  always_comb begin
    j_nxt = j_r;
    for (int g = 0; g < NGRP; g++) begin
      if (grp_any_r[g]) j_nxt = {NGRP_AW'(g), grp_idx_r[g]};
    end
  end

  always_comb begin
    state_nxt     = state_r;
    wsize_nxt     = wsize_r;
    lsize_nxt     = lsize_r;
    fill_nxt      = fill_r;
    head_nxt      = head_r;
    lh_nxt        = lh_r;
    li_nxt        = li_r;
    t_nxt         = t_r;
    len_nxt       = len_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    ctrl.op        = OP_HOLD;
    ctrl.la_byte   = la_r[li_r];
    ctrl.push_byte = la_r[lh_r];

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    if (cfg_we) begin
      if (cfg_index == CFG_WINDOW) wsize_nxt = cfg_wdata;
      else                         lsize_nxt = cfg_wdata[4:0];
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_data.mode == MODE_SEARCH) begin
            lh_nxt    = lh_norm;
            li_nxt    = lh_norm;
            t_nxt     = '0;
            len_nxt   = '0;
            ctrl.op   = OP_LOAD;
            state_nxt = S_CMP;
          end else if (in_data.mode == MODE_LITERAL) begin
            lh_nxt    = lh_norm;
            cnt_nxt   = LEN_W'(1);
            state_nxt = S_CONS;
          end
        end
      end
      S_CMP: begin
        if (any_hit) begin
          ctrl.op = OP_ADV;
          len_nxt = len_r + LEN_W'(1);
          li_nxt  = (LEN_W'(li_r) + LEN_W'(1) >= effl) ? '0 : li_r + LA_AW'(1);
        end
        t_nxt = t_r + LEN_W'(1);
        if (!any_hit || (t_r + LEN_W'(1) == effl)) state_nxt = S_ENC1;
      end
      S_ENC1: state_nxt = S_ENC2;
      S_ENC2: state_nxt = S_RES;
      S_RES: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt        = 1'b1;
          out_nxt.match_length = len_r;
          out_nxt.match_offset = (len_r == '0) ? '0 :
                                 11'(fill_r - FILL_W'(j_r));
          cnt_nxt              = len_r;
          state_nxt            = (len_r == '0) ? S_IDLE : S_CONS;
        end
      end
      S_CONS: begin
        if (full) begin
          ctrl.op  = OP_SHIFT;
          head_nxt = (FILL_W'(head_r) + FILL_W'(1) >= fill_r) ? '0
                                                                : head_r + WIN_AW'(1);
        end else begin
          ctrl.op  = OP_INSERT;
          fill_nxt = fill_r + FILL_W'(1);
        end
        lh_nxt  = (LEN_W'(lh_r) + LEN_W'(1) >= effl) ? '0 : lh_r + LA_AW'(1);
        cnt_nxt = cnt_r - LEN_W'(1);
        if (cnt_r == LEN_W'(1)) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wsize_r     <= 11'(WIN_DEPTH);
      lsize_r     <= 5'(LA_DEPTH);
      fill_r      <= '0;
      head_r      <= '0;
      lh_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wsize_r     <= wsize_nxt;
      lsize_r     <= lsize_nxt;
      fill_r      <= fill_nxt;
      head_r      <= head_nxt;
      lh_r        <= lh_nxt;
      out_valid_r <= out_valid_nxt;
    end
    li_r  <= li_nxt;
    t_r   <= t_nxt;
    len_r <= len_nxt;
    cnt_r <= cnt_nxt;
    out_r <= out_nxt;
    j_r   <= j_nxt;
    for (int g = 0; g < NGRP; g++) begin
      grp_any_r[g] <= grp_any_c[g];
      grp_idx_r[g] <= grp_idx_c[g];
    end
    if (in_xfer && in_data.mode == MODE_LOAD)
      la_r[in_data.position[LA_AW-1:0]] <= in_data.byte_value;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(WIN_DEPTH))
    else $error("window fill beyond depth");
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (len_r <= t_r))
    else $error("match length ahead of step count");
  a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RES))
    else $error("result raised outside result state");
  a_cons_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CONS) |-> (cnt_r != '0))
    else $error("consume with zero count");
`endif

endmodule
`default_nettype wire
